@@ hdl/vtfs_pkg.sv @@
// vtfs_pkg: shared types and constants for the virtual time fair scheduler
// no dependencies
package vtfs_pkg;

    localparam logic [1:0] ACT_WAKE  = 2'd0;
    localparam logic [1:0] ACT_SLEEP = 2'd1;
    localparam logic [1:0] ACT_PICK  = 2'd2;

    localparam logic [0:0] REG_TICKS  = 1'd0;
    localparam logic [0:0] REG_WEIGHT = 1'd1;

    localparam logic [63:0] CSA_UNITS  = 64'd5;
    localparam logic [7:0]  WEIGHT_MAX = 8'd128;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  thread;
        logic [63:0] now_time;
    } vtfs_in_t;

    typedef struct packed {
        logic [2:0]  next_thread;
        logic        next_idle;
        logic        timer_armed;
        logic [63:0] timer_deadline;
    } vtfs_out_t;

    // divider request and reply
    typedef struct packed {
        logic        go;
        logic [95:0] dividend;
        logic [31:0] divisor;
    } vtfs_div_req_t;

    typedef struct packed {
        logic        done;
        logic [95:0] quotient;
        logic [31:0] remainder;
    } vtfs_div_rsp_t;

    function automatic logic [10:0] ratio_of(input logic [63:0] table_w, input logic [2:0] t);
        logic [7:0] w;
        w = table_w[{t, 3'b000} +: 8];
        if (w == 8'd0)
            w = 8'd1;
        if (w > WEIGHT_MAX)
            w = WEIGHT_MAX;
        // 1024 / weight rounded down, weights 1..128
        case (w)
            8'd1:  ratio_of = 11'd1024;
            8'd2:  ratio_of = 11'd512;
            8'd3:  ratio_of = 11'd341;
            8'd4:  ratio_of = 11'd256;
            8'd5:  ratio_of = 11'd204;
            8'd6:  ratio_of = 11'd170;
            8'd7:  ratio_of = 11'd146;
            8'd8:  ratio_of = 11'd128;
            8'd9:  ratio_of = 11'd113;
            8'd10: ratio_of = 11'd102;
            8'd11: ratio_of = 11'd93;
            8'd12: ratio_of = 11'd85;
            8'd13: ratio_of = 11'd78;
            8'd14: ratio_of = 11'd73;
            8'd15: ratio_of = 11'd68;
            8'd16: ratio_of = 11'd64;
            8'd17: ratio_of = 11'd60;
            8'd18: ratio_of = 11'd56;
            8'd19: ratio_of = 11'd53;
            8'd20: ratio_of = 11'd51;
            8'd21: ratio_of = 11'd48;
            8'd22: ratio_of = 11'd46;
            8'd23: ratio_of = 11'd44;
            8'd24: ratio_of = 11'd42;
            8'd25: ratio_of = 11'd40;
            8'd26: ratio_of = 11'd39;
            8'd27: ratio_of = 11'd37;
            8'd28: ratio_of = 11'd36;
            8'd29: ratio_of = 11'd35;
            8'd30: ratio_of = 11'd34;
            8'd31: ratio_of = 11'd33;
            8'd32: ratio_of = 11'd32;
            8'd33: ratio_of = 11'd31;
            8'd34: ratio_of = 11'd30;
            8'd35: ratio_of = 11'd29;
            8'd36: ratio_of = 11'd28;
            8'd37: ratio_of = 11'd27;
            8'd38, 8'd39: ratio_of = 11'd26;
            8'd40: ratio_of = 11'd25;
            8'd41, 8'd42: ratio_of = 11'd24;
            8'd43, 8'd44: ratio_of = 11'd23;
            8'd45, 8'd46: ratio_of = 11'd22;
            8'd47, 8'd48: ratio_of = 11'd21;
            8'd49, 8'd50, 8'd51: ratio_of = 11'd20;
            8'd52, 8'd53: ratio_of = 11'd19;
            8'd54, 8'd55, 8'd56: ratio_of = 11'd18;
            8'd57, 8'd58, 8'd59, 8'd60: ratio_of = 11'd17;
            8'd61, 8'd62, 8'd63, 8'd64: ratio_of = 11'd16;
            8'd65, 8'd66, 8'd67, 8'd68: ratio_of = 11'd15;
            8'd69, 8'd70, 8'd71, 8'd72, 8'd73: ratio_of = 11'd14;
            8'd74, 8'd75, 8'd76, 8'd77, 8'd78: ratio_of = 11'd13;
            8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85: ratio_of = 11'd12;
            8'd86, 8'd87, 8'd88, 8'd89, 8'd90, 8'd91, 8'd92, 8'd93: ratio_of = 11'd11;
            8'd94, 8'd95, 8'd96, 8'd97, 8'd98, 8'd99, 8'd100, 8'd101,
            8'd102: ratio_of = 11'd10;
            8'd103, 8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110,
            8'd111, 8'd112, 8'd113: ratio_of = 11'd9;
            default: ratio_of = 11'd8;
        endcase
    endfunction

endpackage

@@ hdl/vtfs_div.sv @@
// vtfs_div: radix-2 restoring divider, 96-bit dividend by 32-bit divisor
// depends on vtfs_pkg
module vtfs_div
    import vtfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  vtfs_div_req_t req,
    output vtfs_div_rsp_t rsp
);

    logic [95:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], quo_reg[95]};
        diff      = shifted - {1'b0, dsr_reg};
        if (req.go)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd96;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff;
                quo_next = {quo_reg[94:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[94:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[31:0];

endmodule

@@ hdl/virtual_time_fair_scheduler.sv @@
// virtual_time_fair_scheduler: top level, sequencer, thread state and queue
// depends on vtfs_pkg and vtfs_div
// wake and sleep strobe a result after any queue update; pick next with a charge and an
// armed timer makes two passes of the bit-serial divider, one for the charge, one for the timer
// busy falls in the strobe cycle, so one transaction per result; the receiver never stalls
// reset empties the queue, zeroes all thread times and sets the running thread to idle
module virtual_time_fair_scheduler
    import vtfs_pkg::*;
#(
    parameter int THREADS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  vtfs_in_t    in_item,
    output logic        done,
    output vtfs_out_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW = $clog2(THREADS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RM     = 4'd1;
    localparam logic [3:0] S_INS    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DIVA   = 4'd4;
    localparam logic [3:0] S_DIVB   = 4'd5;
    localparam logic [3:0] S_HEAD   = 4'd6;
    localparam logic [3:0] S_DIVC   = 4'd7;
    localparam logic [3:0] S_MULD   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_MUL2   = 4'd10;
    localparam logic [3:0] S_MULD2  = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [TW-1:0] order_reg [THREADS];
    logic [TW-1:0] order_next [THREADS];
    logic [THREADS-1:0] qflag_reg, qflag_next;
    logic [63:0] atime_reg [THREADS];
    logic [63:0] atime_next [THREADS];
    logic [31:0] crem_reg [THREADS];
    logic [31:0] crem_next [THREADS];
    logic [63:0] rstart_reg [THREADS];
    logic [63:0] rstart_next [THREADS];
    logic [CW-1:0] count_reg, count_next;
    logic [63:0] stime_reg, stime_next;
    logic        run_idle_reg, run_idle_next;
    logic [TW-1:0] run_reg, run_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [63:0] wtab_reg, wtab_next;
    vtfs_in_t    item_reg, item_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [TW-1:0] tgt_reg, tgt_next;
    logic        ins_reg, ins_next;
    logic [95:0] acc_reg, acc_next;
    logic [63:0] elapsed_reg, elapsed_next;
    logic        done_reg, done_next;
    vtfs_out_t   res_reg, res_next;
    vtfs_div_req_t dreq;
    vtfs_div_rsp_t drsp;
    logic [2:0]  tgt3;
    logic [TW-1:0] item_t;
    logic        item_ok;
    logic [31:0] mdiv;
    logic [63:0] thr;
    logic [10:0] ratio;
    logic [TW-1:0] at_pos;
    logic [TW-1:0] first_t, second_t;

    vtfs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign item_t  = TW'(in_item.thread);
    assign item_ok = ({29'd0, in_item.thread} < 32'(THREADS));
    assign tgt3    = 3'(tgt_reg);
    assign mdiv    = (ticks_reg == 32'd0) ? 32'd1 : ticks_reg;
    assign ratio   = ratio_of(wtab_reg, tgt3);
    assign at_pos  = order_reg[pos_reg[TW-1:0]];
    assign first_t = order_reg[0];
    assign second_t = order_reg[1];
    assign thr     = stime_reg - CSA_UNITS;

    always_comb
    begin
        state_next   = state_reg;
        order_next   = order_reg;
        qflag_next   = qflag_reg;
        atime_next   = atime_reg;
        crem_next    = crem_reg;
        rstart_next  = rstart_reg;
        count_next   = count_reg;
        stime_next   = stime_reg;
        run_idle_next = run_idle_reg;
        run_next     = run_reg;
        ticks_next   = ticks_reg;
        wtab_next    = wtab_reg;
        item_next    = item_reg;
        pos_next     = pos_reg;
        tgt_next     = tgt_reg;
        ins_next     = ins_reg;
        acc_next     = acc_reg;
        elapsed_next = elapsed_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        dreq         = '0;

        if (cfg_valid && state_reg == S_IDLE)
        begin
            if (cfg_index == REG_TICKS)
                ticks_next = cfg_data[31:0];
            else
                wtab_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = in_item;
                    res_next  = '0;
                    pos_next  = '0;
                    tgt_next  = item_t;
                    case (in_item.action)
                        ACT_WAKE:
                        begin
                            if (item_ok && !qflag_reg[item_t])
                            begin
                                if (!($signed(atime_reg[item_t]) > $signed(thr)))
                                    atime_next[item_t] = stime_reg;
                                state_next = S_INS;
                            end
                            else
                                state_next = S_OUT;
                        end
                        ACT_SLEEP:
                        begin
                            ins_next = 1'b0;
                            state_next = (item_ok && qflag_reg[item_t]) ? S_RM : S_OUT;
                        end
                        ACT_PICK:
                        begin
                            if (!run_idle_reg)
                            begin
                                tgt_next = run_reg;
                                elapsed_next = in_item.now_time - rstart_reg[run_reg];
                                state_next = (in_item.now_time > rstart_reg[run_reg])
                                    ? S_MUL : S_HEAD;
                                ins_next = 1'b1;
                                if (!(in_item.now_time > rstart_reg[run_reg]))
                                    state_next = qflag_reg[run_reg] ? S_RM : S_HEAD;
                            end
                            else
                                state_next = S_HEAD;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end
            S_RM:
            begin
                // find the target, then shift the tail down one slot per cycle
                if (pos_reg + CW'(1) < count_reg)
                begin
                    if (at_pos == tgt_reg)
                    begin
                        order_next[pos_reg[TW-1:0]] = order_reg[pos_reg[TW-1:0] + TW'(1)];
                        order_next[pos_reg[TW-1:0] + TW'(1)] = tgt_reg;
                    end
                    pos_next = pos_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    qflag_next[tgt_reg] = 1'b0;
                    pos_next = '0;
                    state_next = ins_reg ? S_INS : S_OUT;
                end
            end
            S_INS:
            begin
                // bubble the target up from the tail, stopping behind equal keys
                if (pos_reg == '0)
                begin
                    pos_next = count_reg;
                    order_next[count_reg[TW-1:0]] = tgt_reg;
                    count_next = count_reg + CW'(1);
                    qflag_next[tgt_reg] = 1'b1;
                    if (count_reg == '0)
                        state_next = ins_reg ? S_HEAD : S_OUT;
                end
                else
                begin
                    if ($signed(atime_reg[order_reg[pos_reg[TW-1:0] - TW'(1)]])
                        > $signed(atime_reg[tgt_reg]))
                    begin
                        order_next[pos_reg[TW-1:0]] = order_reg[pos_reg[TW-1:0] - TW'(1)];
                        order_next[pos_reg[TW-1:0] - TW'(1)] = tgt_reg;
                        pos_next = pos_reg - CW'(1);
                        if (pos_reg == CW'(1))
                            state_next = ins_reg ? S_HEAD : S_OUT;
                    end
                    else
                        state_next = ins_reg ? S_HEAD : S_OUT;
                end
            end
            S_MUL:
            begin
                acc_next = {32'd0, {32'd0, elapsed_reg[31:0]} * {53'd0, ratio}};
                state_next = S_MULD;
            end
            S_MULD:
            begin
                acc_next = acc_reg + {{32'd0, elapsed_reg[63:32]} * {53'd0, ratio}, 32'd0}
                    + {64'd0, crem_reg[tgt_reg]};
                state_next = S_DIVA;
            end
            S_DIVA:
            begin
                dreq.go = 1'b1;
                dreq.dividend = acc_reg;
                dreq.divisor = mdiv;
                state_next = S_DIVB;
            end
            S_DIVB:
            begin
                if (drsp.done)
                begin
                    atime_next[tgt_reg] = atime_reg[tgt_reg] + drsp.quotient[63:0];
                    crem_next[tgt_reg] = drsp.remainder;
                    pos_next = '0;
                    state_next = qflag_reg[tgt_reg] ? S_RM : S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (count_reg == '0)
                begin
                    run_idle_next = 1'b1;
                    res_next.next_idle = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    stime_next = atime_reg[first_t];
                    rstart_next[first_t] = item_reg.now_time;
                    run_idle_next = 1'b0;
                    run_next = first_t;
                    res_next.next_thread = 3'(first_t);
                    tgt_next = first_t;
                    if (count_reg > CW'(1))
                    begin
                        dreq.go = 1'b1;
                        dreq.dividend = {32'd0, atime_reg[second_t] - atime_reg[first_t]};
                        dreq.divisor = {21'd0, ratio_of(wtab_reg, 3'(first_t))};
                        state_next = S_DIVC;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_DIVC:
            begin
                if (drsp.done)
                begin
                    acc_next = {32'd0, drsp.quotient[63:0] + CSA_UNITS};
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                elapsed_next = {32'd0, acc_reg[31:0]} * {32'd0, ticks_reg};
                state_next = S_MULD2;
            end
            S_MULD2:
            begin
                res_next.timer_armed = 1'b1;
                res_next.timer_deadline = item_reg.now_time + elapsed_reg
                    + {acc_reg[63:32] * ticks_reg, 32'd0};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                done_next = 1'b1;
                ins_next = 1'b0;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            qflag_reg    <= '0;
            count_reg    <= '0;
            stime_reg    <= '0;
            run_idle_reg <= 1'b1;
            run_reg      <= '0;
            ticks_reg    <= 32'd2000000;
            wtab_reg     <= 64'h0101010101010101;
            done_reg     <= 1'b0;
            ins_reg      <= 1'b0;
            for (int i = 0; i < THREADS; i++)
            begin
                atime_reg[i]  <= '0;
                crem_reg[i]   <= '0;
                rstart_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            qflag_reg    <= qflag_next;
            count_reg    <= count_next;
            stime_reg    <= stime_next;
            run_idle_reg <= run_idle_next;
            run_reg      <= run_next;
            ticks_reg    <= ticks_next;
            wtab_reg     <= wtab_next;
            done_reg     <= done_next;
            ins_reg      <= ins_next;
            atime_reg    <= atime_next;
            crem_reg     <= crem_next;
            rstart_reg   <= rstart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg   <= order_next;
        item_reg    <= item_next;
        pos_reg     <= pos_next;
        tgt_reg     <= tgt_next;
        acc_reg     <= acc_next;
        elapsed_reg <= elapsed_next;
        res_reg     <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;

endmodule

@@ verif/tb.sv @@
// tb: self-checking testbench for virtual_time_fair_scheduler
// depends on vtfs_pkg and the scheduler rtl; an in-bench scheduler model
// predicts every result, which is compared field by field on the done strobe
module tb;
    import vtfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTHR = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    vtfs_in_t    in_item;
    logic        done;
    vtfs_out_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [63:0] cfg_data;

    virtual_time_fair_scheduler #(.THREADS(NTHR)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // scheduler model state
    logic [63:0] ticks_cfg;
    logic [63:0] weights_cfg;
    logic [2:0]  rq_order [NTHR];
    int          rq_count;
    bit          rq_flag [NTHR];
    logic [63:0] vtime [NTHR];
    logic [63:0] charge_rem [NTHR];
    logic [63:0] run_from [NTHR];
    logic [63:0] sched_now;
    int          running;

    vtfs_out_t   pending_results [$];
    int          errors;
    int          items_sent;
    int          picks_sent;
    int          idle_cycles;
    int          sender_idle_pct;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] thread_ratio(input int t);
        logic [7:0] w;
        w = weights_cfg[t*8 +: 8];
        if (w == 8'd0)
            w = 8'd1;
        if (w > 8'd128)
            w = 8'd128;
        return 64'(1024 / w);
    endfunction

    function automatic void rq_insert(input int t);
        int p;
        p = 0;
        while (p < rq_count && !($signed(vtime[rq_order[p]]) > $signed(vtime[t])))
            p++;
        for (int k = rq_count; k > p; k--)
            rq_order[k] = rq_order[k-1];
        rq_order[p] = 3'(t);
        rq_count++;
        rq_flag[t] = 1'b1;
    endfunction

    function automatic void rq_remove(input int t);
        int p;
        p = 0;
        while (p < rq_count && rq_order[p] != 3'(t))
            p++;
        if (p >= rq_count)
            return;
        for (int k = p; k + 1 < rq_count; k++)
            rq_order[k] = rq_order[k+1];
        rq_count--;
        rq_flag[t] = 1'b0;
    endfunction

    function automatic void charge_thread(input int t, input logic [63:0] now);
        logic [127:0] acc;
        logic [127:0] unit;
        if (now > run_from[t])
        begin
            unit = (ticks_cfg == 64'd0) ? 128'd1 : 128'(ticks_cfg);
            acc = 128'(now - run_from[t]) * 128'(thread_ratio(t)) + 128'(charge_rem[t]);
            vtime[t] = vtime[t] + 64'(acc / unit);
            charge_rem[t] = 64'(acc % unit);
        end
        if (rq_flag[t])
        begin
            rq_remove(t);
            rq_insert(t);
        end
    endfunction

    function automatic vtfs_out_t schedule_step(input vtfs_in_t it);
        vtfs_out_t r;
        int t;
        int first;
        logic [63:0] gap;
        r = '0;
        t = int'(it.thread);
        if (it.action == ACT_WAKE)
        begin
            if (!rq_flag[t])
            begin
                if (!($signed(vtime[t]) > $signed(sched_now - CSA_UNITS)))
                    vtime[t] = sched_now;
                rq_insert(t);
            end
        end
        else if (it.action == ACT_SLEEP)
        begin
            if (rq_flag[t])
                rq_remove(t);
        end
        else if (it.action == ACT_PICK)
        begin
            if (running < NTHR)
                charge_thread(running, it.now_time);
            if (rq_count > 0)
            begin
                first = int'(rq_order[0]);
                sched_now = vtime[first];
                if (rq_count > 1)
                begin
                    gap = vtime[rq_order[1]] - vtime[first];
                    r.timer_armed = 1'b1;
                    r.timer_deadline = it.now_time
                        + (gap / thread_ratio(first) + CSA_UNITS) * ticks_cfg;
                end
                run_from[first] = it.now_time;
                running = first;
                r.next_thread = 3'(first);
            end
            else
            begin
                running = NTHR;
                r.next_idle = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [2:0] thr,
                             input logic [63:0] now);
        vtfs_in_t it;
        it.action = act;
        it.thread = thr;
        it.now_time = now;
        start <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(schedule_step(it));
        items_sent++;
        if (act == ACT_PICK)
            picks_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
            begin
                @(posedge clk);
                idle_cycles++;
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TICKS)
            ticks_cfg = {32'd0, val[31:0]};
        else
            weights_cfg = val;
        @(posedge clk);
    endtask

    // result checking
    always @(posedge clk)
    begin
        vtfs_out_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.next_thread !== exp_r.next_thread)
                begin
                    $error("next_thread exp %0d got %0d", exp_r.next_thread, result.next_thread);
                    errors++;
                end
                if (result.next_idle !== exp_r.next_idle)
                begin
                    $error("next_idle exp %0d got %0d", exp_r.next_idle, result.next_idle);
                    errors++;
                end
                if (result.timer_armed !== exp_r.timer_armed)
                begin
                    $error("timer_armed exp %0d got %0d", exp_r.timer_armed, result.timer_armed);
                    errors++;
                end
                if (result.timer_deadline !== exp_r.timer_deadline)
                begin
                    $error("timer_deadline exp %h got %h",
                           exp_r.timer_deadline, result.timer_deadline);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** virtual_time_fair_scheduler: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        // extremes, every action, repeat wake, stray sleep, idle pick
        send_item(ACT_PICK, 3'd0, 64'd0);
        send_item(ACT_SLEEP, 3'd5, 64'd0);
        send_item(2'd3, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int t = 0; t < NTHR; t++)
            send_item(ACT_WAKE, 3'(t), 64'd0);
        send_item(ACT_WAKE, 3'd3, 64'd0);
        send_item(ACT_PICK, 3'd0, 64'd1000);
        send_item(ACT_PICK, 3'd0, 64'd500);
        send_item(ACT_PICK, 3'd0, 64'd90_000_000);
        send_item(ACT_SLEEP, 3'd1, 64'd0);
        send_item(ACT_SLEEP, 3'd1, 64'd0);
        send_item(ACT_PICK, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_PICK, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int t = 0; t < NTHR; t++)
            send_item(ACT_SLEEP, 3'(t), 64'd0);
        drain();
    endtask

    task automatic test_registers(input logic [31:0] ticks, input logic [63:0] weights);
        write_reg(REG_TICKS, {$urandom(), ticks});
        write_reg(REG_WEIGHT, weights);
    endtask

    task automatic test_random(input int count, input int idle_pct);
        logic [63:0] clock_now;
        int r;
        sender_idle_pct = idle_pct;
        clock_now = {$urandom(), $urandom()} >> $urandom_range(0, 63);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                send_item(ACT_WAKE, 3'($urandom_range(7)), {$urandom(), $urandom()});
            else if (r < 55)
                send_item(ACT_SLEEP, 3'($urandom_range(7)), {$urandom(), $urandom()});
            else if (r < 93)
            begin
                if ($urandom_range(3) == 0)
                    clock_now = clock_now + {$urandom(), $urandom()};
                else
                    clock_now = clock_now + 64'($urandom_range(0, 50_000_000));
                send_item(ACT_PICK, 3'($urandom_range(7)), clock_now);
            end
            else if (r < 97)
                send_item(ACT_PICK, 3'($urandom_range(7)), {$urandom(), $urandom()});
            else
                send_item(2'd3, 3'($urandom_range(7)), {$urandom(), $urandom()});
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        picks_sent = 0;
        idle_cycles = 0;
        sender_idle_pct = 0;
        ticks_cfg = 64'd2_000_000;
        weights_cfg = 64'h0101_0101_0101_0101;
        rq_count = 0;
        sched_now = '0;
        running = NTHR;
        for (int t = 0; t < NTHR; t++)
        begin
            rq_order[t] = '0;
            rq_flag[t] = 1'b0;
            vtime[t] = '0;
            charge_rem[t] = '0;
            run_from[t] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(180, 19);
        test_registers(32'd0, 64'h80FF_0001_7F81_0240);
        test_directed();
        test_random(180, 71);
        test_registers(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        test_random(180, 0);
        test_registers(32'd1, 64'h0000_0000_0000_0000);
        test_random(180, 19);
        test_registers(32'($urandom_range(1, 5000)), {$urandom(), $urandom()});
        test_random(180, 71);
        test_registers(32'd2_000_000, 64'h0102_0408_1020_4080);
        test_random(180, 0);

        drain();
        repeat (300) @(posedge clk);
        $display("covered %0d transactions (%0d picks), %0d sender idle cycles",
                 items_sent, picks_sent, idle_cycles);
        $display("register settings included zero, one and full-scale ticks and clamped weights");
        if (errors == 0 && pending_results.size() == 0)
            $display("** virtual_time_fair_scheduler: PASSED **");
        else
            $display("** virtual_time_fair_scheduler: FAILED **");
        $finish;
    end

endmodule
